// File: rtl/core/sfr_pkg.sv
// sfr_pkg: constants for the sensor frame receiver
// header/end byte codes and default frame geometry; no dependencies

package sfr_pkg;

    localparam int FRAME_LENGTH_DEF = 24;
    localparam int PAYLOAD_MAX      = 20;
    localparam int IDX_W            = 5;
    localparam int BYTE_W           = 8;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] END_BYTE = 8'hFF;

    localparam logic ST_GOOD = 1'b0;
    localparam logic ST_BAD  = 1'b1;

endpackage

// File: rtl/core/sensor_frame_receiver.sv
// sensor_frame_receiver: fixed-length frame sync receiver with payload replay
// depends on sfr_pkg for header/end codes and frame geometry
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | input     | in_valid/in_ready  | rx_byte
//  out     | output    | out_valid/out_ready| status, payload_byte, payload_index, last
//
// bytes are accepted back to back while in_ready is high; the frame store is written in the accept cycle
// a good frame then gives one payload result per cycle from the single read
// port of the frame store, a bad end byte gives one status result
// no byte is taken while results of a frame are pending; out stalls hold the run
// reset clears count, header state and the output side; the store is not cleared

module sensor_frame_receiver #(
    parameter int FRAME_LENGTH = sfr_pkg::FRAME_LENGTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic [sfr_pkg::BYTE_W-1:0]  payload_byte,
    output logic [sfr_pkg::IDX_W-1:0]   payload_index,
    output logic                        last
);
    import sfr_pkg::*;

    localparam int AW = $clog2(FRAME_LENGTH);
    localparam int PAYLOAD_LEN = (FRAME_LENGTH - 4 > PAYLOAD_MAX) ? PAYLOAD_MAX
                                                                  : FRAME_LENGTH - 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);
    localparam logic [AW-1:0]    PAY_BASE = AW'(2);
    localparam logic [AW:0]      FL_CNT   = (AW+1)'(FRAME_LENGTH);

    typedef enum logic {S_IN, S_OUT} state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                first_hdr_reg, first_hdr_next;
    logic                bad_reg, bad_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW:0]         cnt_inc;
    logic                in_fire, out_fire, is_last;

    logic [BYTE_W-1:0]   frame_mem [FRAME_LENGTH];

    assign in_ready  = (state_reg == S_IN);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign is_last   = bad_reg || (idx_reg == LAST_IDX);
    assign cnt_inc   = {1'b0, cnt_reg} + (AW+1)'(1);

    assign status        = bad_reg;
    assign payload_byte  = bad_reg ? '0 : rd_data_reg;
    assign payload_index = bad_reg ? '0 : idx_reg;
    assign last          = is_last;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        first_hdr_next = first_hdr_reg;
        bad_next       = bad_reg;
        idx_next       = idx_reg;
        case (state_reg)
            S_IN:
            begin
                idx_next = '0;
                if (in_fire)
                begin
                    if (cnt_reg == '0)
                    begin
                        first_hdr_next = (rx_byte == HDR_BYTE);
                        cnt_next       = AW'(1);
                    end
                    else if (cnt_reg == AW'(1))
                    begin
                        // second byte decides header, resync or discard
                        if (!first_hdr_reg && rx_byte == HDR_BYTE)
                        begin
                            first_hdr_next = 1'b1;
                            cnt_next       = AW'(1);
                        end
                        else if (first_hdr_reg && rx_byte == HDR_BYTE)
                        begin
                            cnt_next = AW'(2);
                        end
                        else
                        begin
                            cnt_next = '0;
                        end
                    end
                    else if (cnt_inc == FL_CNT)
                    begin
                        cnt_next   = '0;
                        bad_next   = (rx_byte != END_BYTE);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[AW-1:0];
                    end
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    if (is_last)
                    begin
                        idx_next   = '0;
                        state_next = S_IN;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // read one ahead so the next payload byte is ready after each transaction
    assign rd_addr = PAY_BASE + AW'(idx_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            cnt_reg       <= '0;
            first_hdr_reg <= 1'b0;
            bad_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            first_hdr_reg <= first_hdr_next;
            bad_reg       <= bad_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            frame_mem[cnt_reg] <= rx_byte;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} < FL_CNT))
        else $error("byte count reached frame length");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (in_ready && cnt_reg == '0))
        else $error("frame did not restart after last result");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && !status && idx_reg == $past(idx_reg) + IDX_W'(1)))
        else $error("payload index did not advance");

endmodule

// File: tb/tb_sensor_frame_receiver.sv
`timescale 1ns / 100ps
// tb_sensor_frame_receiver: self-checking bench for the 24-byte frame sync receiver
// predicts payload runs and bad-end status from the byte stream; uses sfr_pkg constants

module tb_sensor_frame_receiver;

    import sfr_pkg::*;

    localparam int FRAME_LEN   = FRAME_LENGTH_DEF;
    localparam int PAYLOAD_LEN = (FRAME_LEN - 4 > PAYLOAD_MAX) ? PAYLOAD_MAX : FRAME_LEN - 4;
    localparam int STREAM_LEN  = 310;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } frame_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte       = '0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic              status;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  payload_index;
    logic              last;

    // byte stream waiting to be sent and results owed by the block
    logic [BYTE_W-1:0] rx_stream[$];
    frame_result_t     frame_results_due[$];

    // predictor state
    logic [BYTE_W-1:0] frame_copy[FRAME_LEN];
    int unsigned       sync_count  = 0;
    bit                hdr_locked  = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned bytes_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned good_frames    = 0;
    int unsigned bad_frames     = 0;
    int unsigned error_count    = 0;
    int          burst_left     = 0;
    int          idle_left      = 0;
    int unsigned stall_mode     = 0;

    sensor_frame_receiver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .last          (last)
    );

    always #5 clk = ~clk;

    // frame sync tracker: stores the byte and queues any results it completes
    task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        if (sync_count >= FRAME_LEN)
            return;
        frame_copy[sync_count] = b;
        sync_count++;
        // second byte is a header byte while the first is not: slip by one
        if (sync_count == 2 && frame_copy[0] != HDR_BYTE && frame_copy[1] == HDR_BYTE)
        begin
            frame_copy[0] = frame_copy[1];
            sync_count = 1;
        end
        if (sync_count >= 2 && !hdr_locked)
        begin
            if (frame_copy[0] == HDR_BYTE && frame_copy[1] == HDR_BYTE)
                hdr_locked = 1'b1;
            else
                sync_count = 0;
        end
        if (sync_count != FRAME_LEN)
            return;
        if (hdr_locked && frame_copy[FRAME_LEN-1] == END_BYTE)
        begin
            for (int k = 0; k < PAYLOAD_LEN; k++)
            begin
                r.status = ST_GOOD;
                r.data   = frame_copy[2+k];
                r.idx    = IDX_W'(k);
                r.last   = (k == PAYLOAD_LEN - 1);
                frame_results_due.push_back(r);
            end
            good_frames++;
        end
        else
        begin
            r.status = ST_BAD;
            r.data   = '0;
            r.idx    = '0;
            r.last   = 1'b1;
            frame_results_due.push_back(r);
            bad_frames++;
        end
        sync_count = 0;
        hdr_locked = 1'b0;
    endtask

    // header, random payload, random unchecked byte, then end byte (or a bad end byte)
    task automatic push_frame(input bit good_end);
        rx_stream.push_back(HDR_BYTE);
        rx_stream.push_back(HDR_BYTE);
        for (int k = 0; k < PAYLOAD_LEN; k++)
            rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
        rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
        rx_stream.push_back(good_end ? END_BYTE : BYTE_W'($urandom_range(0, 254)));
    endtask

    // sender: bursts of transactions separated by random idle gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                track_rx_byte(rx_byte);
                bytes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (idle_left > 0)
                begin
                    in_valid <= 1'b0;
                    idle_left--;
                end
                else if (rx_stream.size() > 0)
                begin
                    rx_byte  <= rx_stream.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 32);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: out_ready follows one of four stall modes, picked at random
    always @(posedge clk)
    begin
        if (cycle_count % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= (cycle_count % 5 != 0);
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // checker: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (frame_results_due.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected result status=%0d byte=%02h idx=%0d last=%0d",
                             status, payload_byte, payload_index, last);
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (status !== want.status || payload_byte !== want.data ||
                    payload_index !== want.idx || last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("ERROR: result mismatch: expected status=%0d byte=%02h idx=%0d last=%0d",
                                 want.status, want.data, want.idx, want.last);
                        $display("       got status=%0d byte=%02h idx=%0d last=%0d",
                                 status, payload_byte, payload_index, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int unsigned pick;
        // bad header discards both bytes, then neither byte a header byte
        rx_stream.push_back(HDR_BYTE);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'h00);
        // slip onto the second byte, then a good frame with extreme payload bytes
        rx_stream.push_back(8'h12);
        rx_stream.push_back(HDR_BYTE);
        rx_stream.push_back(HDR_BYTE);
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        rx_stream.push_back(8'h01);
        rx_stream.push_back(8'h80);
        rx_stream.push_back(HDR_BYTE);
        rx_stream.push_back(8'h55);
        rx_stream.push_back(8'h7F);
        rx_stream.push_back(8'hFE);
        for (int k = 8; k < PAYLOAD_LEN; k++)
            rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
        rx_stream.push_back(8'h00);    // byte before the end byte is not checked
        rx_stream.push_back(END_BYTE);

        // mostly full frames, some with a bad end byte, plus noise, slips and cut-short frames
        while (rx_stream.size() < STREAM_LEN)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                push_frame($urandom_range(0, 3) != 0);
            else if (pick == 7)
                repeat ($urandom_range(1, 3))
                    rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
            else if (pick == 8)
            begin
                rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
                push_frame(1'b1);
            end
            else
            begin
                rx_stream.push_back(HDR_BYTE);
                rx_stream.push_back(HDR_BYTE);
                repeat ($urandom_range(1, 15))
                    rx_stream.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        #1;
        while (rx_stream.size() != 0 || in_valid)
        begin
            @(posedge clk);
            #1;
        end
        while (frame_results_due.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        #1;

        if (frame_results_due.size() != 0)
        begin
            error_count++;
            $display("ERROR: %0d predicted results never arrived", frame_results_due.size());
        end
        $display("sent %0d bytes: %0d good frames, %0d bad-end frames", bytes_sent,
                 good_frames, bad_frames);
        $display("checked %0d result transactions, %0d errors", results_seen, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sfr_pkg.sv
rtl/core/sensor_frame_receiver.sv
tb/tb_sensor_frame_receiver.sv
